// ===== hw/rtl/readability_text_statistics_defines.svh =====
// Assertion macros shared by the checker of the readability statistics block.
// Needs nothing else; each macro expands to one clocked concurrent assertion.
`ifndef READABILITY_TEXT_STATISTICS_DEFINES_SVH
`define READABILITY_TEXT_STATISTICS_DEFINES_SVH

// Implication in the same cycle.
`define RTS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle.
`define RTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rts_pkg.sv =====
// Shared types and constants of the readability statistics block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package rts_pkg;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 88;
    localparam int TOTAL_W    = 16;
    localparam int INDEX_W    = 34;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Divider widths: numerator 2*|diff| + W*S, denominator 2*W*S.
    localparam int DIVD_W = 52;
    localparam int DIVS_W = 33;
    localparam int QUO_W  = 34;

    // Index constants in thousandths.
    localparam logic [MUL_B_W-1:0] K_BASE = 18'd206835;
    localparam logic [MUL_B_W-1:0] K_SYL  = 18'd84600;
    localparam logic [MUL_B_W-1:0] K_WORD = 18'd1015;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 16'hFFFF;

    typedef struct packed {
        logic [TOTAL_W-1:0] sentences;
        logic [TOTAL_W-1:0] words;
        logic [TOTAL_W-1:0] syllables;
        logic               no_words;
    } t_totals;

endpackage

`default_nettype wire

// ===== hw/rtl/rts_count.sv =====
// Byte classifier and saturating sentence, word and syllable counters.
// Depends on rts_pkg for the totals struct and output widths.
`default_nettype none

module rts_count #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [rts_pkg::IN_DATA_W-1:0] i_byte,
    input  wire logic                          i_last,
    output rts_pkg::t_totals                   o_totals
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [7:0]            GROUP_MAX = 8'hFF;

    logic [COUNT_BITS-1:0] r_marks, r_words, r_syls;
    logic [7:0]            r_groups;
    logic                  r_in_word, r_prev, r_prev2, r_last_e;
    logic [1:0]            r_len;

    logic [COUNT_BITS-1:0] n_marks, n_words, n_syls;
    logic [7:0]            n_groups;
    logic [1:0]            n_len;

    logic                  mark, sep, vowel, is_e;
    logic [7:0]            lower;
    logic [7:0]            cl_groups, syl_a, syl;
    logic                  cl_prev2, cl_last_e, cl_len_two, do_close, strip;
    logic [COUNT_BITS:0]   syl_sum, sent_wide;
    logic [COUNT_BITS-1:0] sent;

    function automatic logic [rts_pkg::TOTAL_W-1:0] clamp_out(input logic [COUNT_BITS-1:0] v);
        if (v > COUNT_BITS'(rts_pkg::TOTAL_MAX)) begin
            return rts_pkg::TOTAL_MAX;
        end
        return rts_pkg::TOTAL_W'(v);
    endfunction

    always_comb begin
        mark  = (i_byte == 8'h2E) || (i_byte == 8'h3F) || (i_byte == 8'h21)
             || (i_byte == 8'h3A) || (i_byte == 8'h3B);
        sep   = mark || (i_byte == 8'h20);
        lower = (i_byte >= 8'h41 && i_byte <= 8'h5A) ? i_byte + 8'd32 : i_byte;
        vowel = (lower == 8'h61) || (lower == 8'h65) || (lower == 8'h69)
             || (lower == 8'h6F) || (lower == 8'h75) || (lower == 8'h79);
        is_e  = (lower == 8'h65);

        // Word state once this byte has joined the open word.
        n_groups = (vowel && !r_prev && r_groups != GROUP_MAX) ? r_groups + 8'd1 : r_groups;
        n_len    = (r_len == 2'd2) ? 2'd2 : r_len + 2'd1;

        // A separator closes the word as it stood; a final letter closes it with itself.
        cl_groups  = sep ? r_groups : n_groups;
        cl_prev2   = sep ? r_prev2 : r_prev;
        cl_last_e  = sep ? r_last_e : is_e;
        cl_len_two = sep ? (r_len == 2'd2) : (n_len == 2'd2);
        do_close   = sep ? r_in_word : i_last;

        strip = cl_last_e && cl_len_two && !cl_prev2 && (cl_groups != 8'd0);
        syl_a = cl_groups - {7'd0, strip};
        syl   = (syl_a == 8'd0) ? 8'd1 : syl_a;

        n_words = (do_close && r_words != COUNT_MAX) ? r_words + COUNT_BITS'(1) : r_words;
        syl_sum = {1'b0, r_syls} + (COUNT_BITS+1)'(syl);
        if (!do_close) begin
            n_syls = r_syls;
        end else if (syl_sum > {1'b0, COUNT_MAX}) begin
            n_syls = COUNT_MAX;
        end else begin
            n_syls = syl_sum[COUNT_BITS-1:0];
        end
        n_marks = (mark && r_marks != COUNT_MAX) ? r_marks + COUNT_BITS'(1) : r_marks;

        sent_wide = {1'b0, n_marks} + (COUNT_BITS+1)'(1) - (COUNT_BITS+1)'(mark);
        sent      = (sent_wide > {1'b0, COUNT_MAX}) ? COUNT_MAX : sent_wide[COUNT_BITS-1:0];

        o_totals.sentences = clamp_out(sent);
        o_totals.words     = clamp_out(n_words);
        o_totals.syllables = clamp_out(n_syls);
        o_totals.no_words  = (n_words == '0) || (sent == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marks   <= '0;
            r_words   <= '0;
            r_syls    <= '0;
            r_groups  <= '0;
            r_in_word <= 1'b0;
            r_prev    <= 1'b0;
            r_prev2   <= 1'b0;
            r_last_e  <= 1'b0;
            r_len     <= '0;
        end else if (i_valid) begin
            if (i_last) begin
                r_marks   <= '0;
                r_words   <= '0;
                r_syls    <= '0;
                r_groups  <= '0;
                r_in_word <= 1'b0;
                r_prev    <= 1'b0;
                r_prev2   <= 1'b0;
                r_last_e  <= 1'b0;
                r_len     <= '0;
            end else begin
                r_marks <= n_marks;
                r_words <= n_words;
                r_syls  <= n_syls;
                if (sep) begin
                    r_groups  <= '0;
                    r_in_word <= 1'b0;
                    r_prev    <= 1'b0;
                    r_prev2   <= 1'b0;
                    r_last_e  <= 1'b0;
                    r_len     <= '0;
                end else begin
                    r_groups  <= n_groups;
                    r_in_word <= 1'b1;
                    r_prev    <= vowel;
                    r_prev2   <= r_prev;
                    r_last_e  <= is_e;
                    r_len     <= n_len;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rts_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Depends on rts_pkg for operand and product widths.
`default_nettype none

module rts_mul (
    input  wire logic                        i_clk,
    input  wire logic [rts_pkg::MUL_A_W-1:0] i_a,
    input  wire logic [rts_pkg::MUL_B_W-1:0] i_b,
    output logic      [rts_pkg::PROD_W-1:0]  o_p
);

    always_ff @(posedge i_clk) begin
        o_p <= rts_pkg::PROD_W'(i_a) * rts_pkg::PROD_W'(i_b);
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rts_div.sv =====
// Restoring divider producing one quotient bit per cycle.
// Depends on rts_pkg for the numerator, denominator and quotient widths.
`default_nettype none

module rts_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [rts_pkg::DIVD_W-1:0] i_dividend,
    input  wire logic [rts_pkg::DIVS_W-1:0] i_divisor,
    output logic                            o_done,
    output logic      [rts_pkg::QUO_W-1:0]  o_quotient
);

    localparam int CNT_W = $clog2(rts_pkg::QUO_W + 1);

    logic [rts_pkg::DIVS_W-1:0] r_rem, r_div, n_rem;
    logic [rts_pkg::QUO_W-1:0]  r_quo;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_done;
    logic [rts_pkg::DIVS_W:0]   trial;
    logic                       fits;

    // The caller guarantees the quotient fits, so the top numerator bits stay below the divisor.
    always_comb begin
        trial = {r_rem, r_quo[rts_pkg::QUO_W-1]};
        fits  = (trial >= {1'b0, r_div});
        n_rem = fits ? rts_pkg::DIVS_W'(trial - {1'b0, r_div})
                     : trial[rts_pkg::DIVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_rem  <= rts_pkg::DIVS_W'(i_dividend[rts_pkg::DIVD_W-1:rts_pkg::QUO_W]);
            r_quo  <= i_dividend[rts_pkg::QUO_W-1:0];
            r_div  <= i_divisor;
            r_cnt  <= CNT_W'(rts_pkg::QUO_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_rem  <= n_rem;
            r_quo  <= {r_quo[rts_pkg::QUO_W-2:0], fits};
            r_cnt  <= r_cnt - CNT_W'(1);
            r_done <= (r_cnt == CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== hw/rtl/readability_text_statistics.sv =====
// Top level of the readability statistics block: counters, sequencer, output register.
// Depends on rts_pkg, rts_count, rts_mul and rts_div.
//
//  channel  | dir | handshake               | payload
//  s_axis   | in  | s_axis_tvalid/tready    | tdata: text_byte; tlast: end_of_phrase
//  m_axis   | out | m_axis_tvalid/tready    | tdata: totals and index; tuser: no_words_error
//
// An ordinary byte is taken and the block is ready again at once.
// The final byte of a phrase keeps the input closed after it is taken, while the
// sequencer makes six passes through the shared multiplier, a sum, a difference and a
// divider start, then waits on the bit-per-cycle divider and loads the result.
// A phrase with no words skips the arithmetic and goes straight to S_OUT.
// A result still waiting in the output register holds the next one in S_OUT, with the
// input closed, until that transaction completes.
// Reset is synchronous, active low, and clears all counters and the sequencer.
`default_nettype none

module readability_text_statistics #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: [7:0] text_byte
    input  wire logic [rts_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic                           s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // tdata: [15:0] sentence_total, [31:16] word_total, [47:32] syllable_total,
    //        [81:48] index_milli, [87:82] zero
    output logic      [rts_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: [0] no_words_error
    output logic                                m_axis_tuser
);

    typedef enum logic [3:0] {
        S_IDLE, S_WS, S_POS, S_YS, S_NEGA, S_WW, S_NEGB,
        S_SUM, S_DIFF, S_NUM, S_DIV, S_OUT
    } t_state;

    t_state                      r_state;
    rts_pkg::t_totals            totals, r_tot;
    logic [rts_pkg::MUL_A_W-1:0] mul_a;
    logic [rts_pkg::MUL_B_W-1:0] mul_b;
    logic [rts_pkg::PROD_W-1:0]  prod;
    logic [31:0]                 r_d;
    logic [rts_pkg::PROD_W-1:0]  r_pos, r_neg, r_mag;
    logic                        r_negative;
    logic                        r_div_start;
    logic                        div_done;
    logic [rts_pkg::QUO_W-1:0]   quotient;
    logic [rts_pkg::DIVD_W-1:0]  dividend;
    logic [rts_pkg::DIVS_W-1:0]  divisor;
    logic [rts_pkg::INDEX_W-1:0] r_index;
    logic [rts_pkg::OUT_DATA_W-1:0] r_out_data;
    logic                        r_out_err, r_out_valid;
    logic                        in_fire, out_fire, out_load;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = r_out_valid && m_axis_tready;
    assign out_load      = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);

    rts_count #(
        .COUNT_BITS (COUNT_BITS)
    ) u_count (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (in_fire),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_totals (totals)
    );

    always_comb begin
        unique case (r_state)
            S_WS:   begin mul_a = 32'(r_tot.words);     mul_b = 18'(r_tot.sentences); end
            S_POS:  begin mul_a = prod[31:0];           mul_b = rts_pkg::K_BASE;      end
            S_YS:   begin mul_a = 32'(r_tot.syllables); mul_b = 18'(r_tot.sentences); end
            S_NEGA: begin mul_a = prod[31:0];           mul_b = rts_pkg::K_SYL;       end
            S_WW:   begin mul_a = 32'(r_tot.words);     mul_b = 18'(r_tot.words);     end
            S_NEGB: begin mul_a = prod[31:0];           mul_b = rts_pkg::K_WORD;      end
            default: begin mul_a = '0;                  mul_b = '0;                   end
        endcase
    end

    rts_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // Rounded quotient: (2*|diff| + d) / (2*d).
    assign dividend = rts_pkg::DIVD_W'({r_mag, 1'b0}) + rts_pkg::DIVD_W'(r_d);
    assign divisor  = {r_d, 1'b0};

    rts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= (r_state == S_NUM);
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire && s_axis_tlast) begin
                        r_tot   <= totals;
                        r_index <= '0;
                        r_state <= totals.no_words ? S_OUT : S_WS;
                    end
                end
                S_WS:   r_state <= S_POS;
                S_POS: begin
                    r_d     <= prod[31:0];
                    r_state <= S_YS;
                end
                S_YS: begin
                    r_pos   <= prod;
                    r_state <= S_NEGA;
                end
                S_NEGA: r_state <= S_WW;
                S_WW: begin
                    r_neg   <= prod;
                    r_state <= S_NEGB;
                end
                S_NEGB: r_state <= S_SUM;
                S_SUM: begin
                    r_neg   <= r_neg + prod;
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    if (r_pos >= r_neg) begin
                        r_mag      <= r_pos - r_neg;
                        r_negative <= 1'b0;
                    end else begin
                        r_mag      <= r_neg - r_pos;
                        r_negative <= 1'b1;
                    end
                    r_state <= S_NUM;
                end
                S_NUM: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_index <= r_negative ? -quotient : quotient;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out_data  <= {6'd0, r_index, r_tot.syllables,
                                        r_tot.words, r_tot.sentences};
                        r_out_err   <= r_tot.no_words;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_err;

endmodule

`default_nettype wire

// ===== hw/rtl/rts_checker.sv =====
// Port-level checks of the readability statistics block, bound to its top level.
// Depends on rts_pkg and the assertion macros in readability_text_statistics_defines.svh.
`default_nettype none
`include "readability_text_statistics_defines.svh"

module rts_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic [rts_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input wire logic                           s_axis_tlast,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [rts_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic                           m_axis_tuser
);

    // A held result keeps its value until the transaction completes.
    `RTS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
    // The final byte moves the sequencer out of idle, so no byte is taken in the next cycle.
    `RTS_ASSERT_NEXT(a_busy_after_last, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "byte accepted during index computation")
    `RTS_ASSERT_SAME(a_err_index_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata[81:48] == 34'd0, "index not zero with error flag")
    `RTS_ASSERT_SAME(a_words_present, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[31:16] != 16'd0, "no words without error flag")
    // Every word counts at least one syllable.
    `RTS_ASSERT_SAME(a_syl_ge_words, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[47:32] >= m_axis_tdata[31:16], "fewer syllables than words")

endmodule

bind readability_text_statistics rts_checker u_rts_checker (.*);

`default_nettype wire

// ===== bench/readability_text_statistics_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the readability statistics block: rebuilds the phrase totals and the
// reading ease index from the accepted bytes and compares them with each result.
// Depends on rts_pkg for the channel widths.
module readability_text_statistics_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_byte_valid,
    input  wire logic                           i_byte_ready,
    input  wire logic [rts_pkg::IN_DATA_W-1:0]  i_byte_data,
    input  wire logic                           i_byte_last,
    input  wire logic                           i_stats_valid,
    input  wire logic                           i_stats_ready,
    input  wire logic [rts_pkg::OUT_DATA_W-1:0] i_stats_data,
    input  wire logic                           i_stats_user,
    output int                                  o_error_count,
    output int                                  o_pending
);

    localparam int unsigned COUNT_MAX = 65535;
    localparam int unsigned GROUP_MAX = 255;

    typedef struct {
        logic [15:0] sentences;
        logic [15:0] words;
        logic [15:0] syllables;
        logic [33:0] index;
        logic        no_words;
    } phrase_stats_t;

    phrase_stats_t expected_stats[$];

    // Running totals of the phrase in progress and of the open word.
    int unsigned mark_tally;
    int unsigned word_tally;
    int unsigned syllable_tally;
    int unsigned vowel_groups;
    int unsigned word_len;
    bit          word_open;
    bit          last_vowel;
    bit          prior_vowel;
    bit          ends_in_e;

    function automatic bit is_mark(input logic [7:0] c);
        return c == "." || c == "?" || c == "!" || c == ":" || c == ";";
    endfunction

    function automatic bit is_vowel_like(input logic [7:0] c);
        logic [7:0] low;
        low = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        return low == "a" || low == "e" || low == "i" || low == "o" || low == "u" ||
               low == "y";
    endfunction

    // Index in thousandths, rounded to nearest with ties away from zero.
    function automatic logic [33:0] reading_ease_milli(input logic [63:0] words,
                                                       input logic [63:0] sentences,
                                                       input logic [63:0] syllables);
        logic [63:0] denom;
        logic [63:0] plus;
        logic [63:0] minus;
        logic [63:0] quot;
        logic [63:0] negated;
        denom = words * sentences;
        plus  = 64'd206835 * denom;
        minus = 64'd84600 * syllables * sentences + 64'd1015 * words * words;
        if (plus >= minus) begin
            quot = (64'd2 * (plus - minus) + denom) / (64'd2 * denom);
            return quot[33:0];
        end
        quot    = (64'd2 * (minus - plus) + denom) / (64'd2 * denom);
        negated = -quot;
        return negated[33:0];
    endfunction

    task automatic clear_word();
        vowel_groups = 0;
        word_len     = 0;
        word_open    = 1'b0;
        last_vowel   = 1'b0;
        prior_vowel  = 1'b0;
        ends_in_e    = 1'b0;
    endtask

    task automatic close_word();
        int unsigned syl;
        if (!word_open)
            return;
        syl = vowel_groups;
        // A silent final e only counts off when a consonant-like byte precedes it.
        if (ends_in_e && word_len >= 2 && !prior_vowel && syl > 0)
            syl--;
        if (syl < 1)
            syl = 1;
        if (word_tally < COUNT_MAX)
            word_tally++;
        syllable_tally = (syllable_tally + syl > COUNT_MAX) ? COUNT_MAX :
                         syllable_tally + syl;
        clear_word();
    endtask

    task automatic take_byte(input logic [7:0] c, input logic last);
        bit            mark;
        bit            vowel;
        int unsigned   sent;
        phrase_stats_t stats;
        mark = is_mark(c);
        if (mark && mark_tally < COUNT_MAX)
            mark_tally++;
        if (mark || c == " ") begin
            close_word();
        end else begin
            vowel     = is_vowel_like(c);
            word_open = 1'b1;
            if (vowel && !last_vowel && vowel_groups < GROUP_MAX)
                vowel_groups++;
            prior_vowel = last_vowel;
            last_vowel  = vowel;
            ends_in_e   = (c == "e" || c == "E");
            if (word_len < 2)
                word_len++;
        end
        if (!last)
            return;
        close_word();
        sent = mark_tally + 1 - mark;
        if (sent > COUNT_MAX)
            sent = COUNT_MAX;
        stats.sentences = sent[15:0];
        stats.words     = word_tally[15:0];
        stats.syllables = syllable_tally[15:0];
        stats.no_words  = (word_tally == 0 || sent == 0);
        stats.index     = stats.no_words ? '0 :
                          reading_ease_milli(word_tally, sent, syllable_tally);
        expected_stats.push_back(stats);
        mark_tally     = 0;
        word_tally     = 0;
        syllable_tally = 0;
        clear_word();
    endtask

    task automatic compare_field(input string field, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            o_error_count++;
        end
    endtask

    task automatic check_stats();
        phrase_stats_t want;
        if (expected_stats.size() == 0) begin
            $display("%0t: result with no phrase pending, expected none, got tdata %h tuser %b",
                     $time, i_stats_data, i_stats_user);
            o_error_count++;
            return;
        end
        want = expected_stats.pop_front();
        compare_field("sentence_total", want.sentences, i_stats_data[15:0]);
        compare_field("word_total", want.words, i_stats_data[31:16]);
        compare_field("syllable_total", want.syllables, i_stats_data[47:32]);
        compare_field("index_milli", longint'($signed(want.index)),
                      longint'($signed(i_stats_data[81:48])));
        compare_field("tdata padding", 0, i_stats_data[87:82]);
        compare_field("no_words_error", want.no_words, i_stats_user);
    endtask

    // A result leaves only after its final byte has been taken and the result registered,
    // so the order of the two channels within one edge does not matter.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_stats_valid && i_stats_ready)
                check_stats();
            if (i_byte_valid && i_byte_ready)
                take_byte(i_byte_data, i_byte_last);
        end
        o_pending <= expected_stats.size();
    end

endmodule

// ===== bench/readability_text_statistics_tb.sv =====
`timescale 1ns / 1ps
// Top of the readability statistics testbench: clock, reset, byte stimulus and verdict.
// Depends on rts_pkg, the block readability_text_statistics and the scoreboard module.
module readability_text_statistics_tb;

    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int PHASE_ITEMS  = 100;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    // tdata: [7:0] text_byte
    logic [rts_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic                           s_axis_tlast;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    // tdata: [15:0] sentence_total, [31:16] word_total, [47:32] syllable_total,
    //        [81:48] index_milli, [87:82] zero
    logic [rts_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    // tuser: [0] no_words_error
    logic                           m_axis_tuser;

    int error_count;
    int pending_results;
    int sender_idle_pct;
    int stall_pct;
    int bytes_sent;
    int cycle_count;

    readability_text_statistics u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    readability_text_statistics_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte_valid  (s_axis_tvalid),
        .i_byte_ready  (s_axis_tready),
        .i_byte_data   (s_axis_tdata),
        .i_byte_last   (s_axis_tlast),
        .i_stats_valid (m_axis_tvalid),
        .i_stats_ready (m_axis_tready),
        .i_stats_data  (m_axis_tdata),
        .i_stats_user  (m_axis_tuser),
        .o_error_count (error_count),
        .o_pending     (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Holds the byte until the transaction completes; idle cycles come first.
    task automatic send_byte(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_phrase(input string text);
        for (int i = 0; i < text.len(); i++)
            send_byte(text[i], i == text.len() - 1);
    endtask

    function automatic logic [7:0] random_text_byte();
        string vowels;
        string consonants;
        string marks;
        int    roll;
        vowels     = "aeiouyAEIOUY";
        consonants = "bcdfghjklmnpqrstvwxzBCDFGHJKLMNPQRSTVWXZ";
        marks      = ".?!:;";
        roll       = $urandom_range(99);
        if (roll < 30)
            return vowels[$urandom_range(vowels.len() - 1)];
        if (roll < 55)
            return consonants[$urandom_range(consonants.len() - 1)];
        if (roll < 65)
            return ($urandom_range(1) != 0) ? "e" : "E";
        if (roll < 79)
            return " ";
        if (roll < 87)
            return marks[$urandom_range(marks.len() - 1)];
        return 8'($urandom_range(255));
    endfunction

    task automatic send_random_phrase();
        int length;
        length = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int i = 0; i < length; i++)
            send_byte(random_text_byte(), i == length - 1);
    endtask

    initial begin
        int target;
        sender_idle_pct = 0;
        stall_pct       = 0;
        bytes_sent      = 0;
        i_rst_n        <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        s_axis_tlast   <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Short phrases: lone e, empty phrases, silent e, odd bytes, marks, negative index.
        send_phrase("e");
        send_phrase(" ");
        send_phrase(".");
        send_phrase("bE");
        send_byte(8'hFF, 1'b0);
        send_byte(8'h09, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b1);
        send_phrase("Yo! ai?");
        send_phrase("a;b:c");
        send_phrase("ababab");

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct = 0;
                    stall_pct       = 0;
                end
                1: begin
                    sender_idle_pct = 69;
                    stall_pct       = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    stall_pct       = 69;
                end
                default: begin
                    sender_idle_pct = 19;
                    stall_pct       = 19;
                end
            endcase
            target = bytes_sent + PHASE_ITEMS;
            while (bytes_sent < target)
                send_random_phrase();
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
